// ===== rtl/skcc_pkg.sv =====
// ----------------------------------------------------------------------------
// skcc_pkg
// Shared constants, types and helpers for the sort key column compare core.
// ----------------------------------------------------------------------------
package skcc_pkg;

   localparam int ROWS        = 4096;
   localparam int ROW_AW      = $clog2(ROWS);
   localparam int ROW_W       = 12;
   localparam int VALUE_W     = 64;
   localparam int VALUE_WIDTH = 64;   // bits actually compared, 8..64
   localparam int TIE_W       = 13;

   localparam logic       OP_LOAD    = 1'b0;
   localparam logic       OP_COMPARE = 1'b1;

   // two-bit signed three-way codes
   localparam logic [1:0] RES_TIED   = 2'b00;
   localparam logic [1:0] RES_AFTER  = 2'b01;
   localparam logic [1:0] RES_BEFORE = 2'b11;

   localparam logic [TIE_W-1:0] TIE_MAX = {TIE_W{1'b1}};

   typedef struct packed {
      logic              en;
      logic [ROW_AW-1:0] addr;
      logic [1:0]        data;
   } skcc_wr_type;

   typedef struct packed {
      logic descending;
      logic null_sign_neg;
      logic value_null;
      logic key_null;
   } skcc_flags_type;

   // +1 or -1 from a sign bit
   function automatic logic [1:0] unit_code(input logic neg);
      return neg ? RES_BEFORE : RES_AFTER;
   endfunction

   // load pattern: 0 -> 0, 1 -> +1, anything else -> -1
   function automatic logic [1:0] init_code(input logic [1:0] bits);
      logic [1:0] r;
      unique case (bits)
         2'b00:   r = RES_TIED;
         2'b01:   r = RES_AFTER;
         default: r = RES_BEFORE;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/skcc_if.sv =====
// ----------------------------------------------------------------------------
// skcc_if
// Valid/ready channels for compare items and result words.
// ----------------------------------------------------------------------------
interface skcc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [skcc_pkg::ROW_W-1:0]           row;
   logic signed [1:0]                    init_result;
   logic signed [skcc_pkg::VALUE_W-1:0]  value;
   logic                                 value_null;
   logic signed [skcc_pkg::VALUE_W-1:0]  key_value;
   logic                                 key_null;
   logic                                 descending;
   logic                                 null_sign_neg;
   logic                                 first_of_column;

   modport source (
      output valid, op, row, init_result, value, value_null, key_value, key_null,
             descending, null_sign_neg, first_of_column,
      input  ready
   );
   modport sink (
      input  valid, op, row, init_result, value, value_null, key_value, key_null,
             descending, null_sign_neg, first_of_column,
      output ready
   );
endinterface

interface skcc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [skcc_pkg::ROW_W-1:0]       out_row;
   logic signed [1:0]                result;
   logic [skcc_pkg::TIE_W-1:0]       tied_count;

   modport source (
      output valid, out_row, result, tied_count,
      input  ready
   );
   modport sink (
      input  valid, out_row, result, tied_count,
      output ready
   );
endinterface

// ===== rtl/skcc_row_store.sv =====
// ----------------------------------------------------------------------------
// skcc_row_store
// Per-row three-way result memory, one write and one registered read port,
// with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module skcc_row_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [skcc_pkg::ROW_AW-1:0]   rd_addr,
   output logic [1:0]                    rd_data,
   input  skcc_pkg::skcc_wr_type         wr,
   output logic                          busy
);

   logic [1:0]                  mem_ff [skcc_pkg::ROWS];
   logic [1:0]                  rd_data_ff;
   logic                        clearing_ff, clearing_in;
   logic [skcc_pkg::ROW_AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic                        we;
   logic [skcc_pkg::ROW_AW-1:0] wa;
   logic [1:0]                  wd;

   always_comb begin
      clearing_in = clearing_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == skcc_pkg::ROW_AW'(skcc_pkg::ROWS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   // sweep owns the write port until done; no items are taken meanwhile
   assign we = clearing_ff | wr.en;
   assign wa = clearing_ff ? clr_ptr_ff : wr.addr;
   assign wd = clearing_ff ? skcc_pkg::RES_TIED : wr.data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

// ===== rtl/skcc_cmp.sv =====
// ----------------------------------------------------------------------------
// skcc_cmp
// Fresh three-way result of one row value against the key, with null order.
// ----------------------------------------------------------------------------
module skcc_cmp (
   input  logic signed [skcc_pkg::VALUE_W-1:0] value,
   input  logic signed [skcc_pkg::VALUE_W-1:0] key_value,
   input  skcc_pkg::skcc_flags_type            flags,
   output logic [1:0]                          fresh
);

   logic signed [skcc_pkg::VALUE_WIDTH-1:0] a;
   logic signed [skcc_pkg::VALUE_WIDTH-1:0] b;
   logic                                    lt;
   logic                                    eq;
   logic                                    d_neg;

   assign a     = value[skcc_pkg::VALUE_WIDTH-1:0];
   assign b     = key_value[skcc_pkg::VALUE_WIDTH-1:0];
   assign lt    = a < b;
   assign eq    = a == b;
   assign d_neg = flags.descending ^ flags.null_sign_neg;

   always_comb begin
      priority if (flags.value_null && flags.key_null) begin
         fresh = skcc_pkg::RES_TIED;
      end else if (flags.value_null) begin
         fresh = skcc_pkg::unit_code(d_neg);
      end else if (flags.key_null) begin
         fresh = skcc_pkg::unit_code(!d_neg);
      end else if (eq) begin
         fresh = skcc_pkg::RES_TIED;
      end else begin
         fresh = skcc_pkg::unit_code(lt ^ flags.descending);
      end
   end

endmodule

// ===== rtl/sort_key_column_compare_core.sv =====
// ----------------------------------------------------------------------------
// sort_key_column_compare_core
// Pipeline: two stages (store read, then compare/write-back into the output
// register); a full output register holds stage 1 until rsp.ready.
// Throughput: one word per cycle while rsp accepts, set by the single
// read-modify-write of the row store; back-to-back hits on the same row
// are forwarded. Reset: synchronous; afterwards the row store is zeroed,
// with req.ready low until the sweep ends. The tie count resets to zero.
// ----------------------------------------------------------------------------
module sort_key_column_compare_core (
   input  logic               clock,
   input  logic               reset,
   skcc_req_if.sink           req,
   skcc_rsp_if.source         rsp
);

   logic                                accept;
   logic                                advance;
   logic                                busy;
   logic [1:0]                          rd_data;
   skcc_pkg::skcc_wr_type               wr;
   skcc_pkg::skcc_flags_type            flags;
   logic [1:0]                          fresh;
   logic [1:0]                          old;
   logic [1:0]                          r;
   logic [skcc_pkg::TIE_W-1:0]          cnt_base;
   logic [skcc_pkg::TIE_W-1:0]          tie_in;
   logic [skcc_pkg::ROW_AW-1:0]         s1_idx;
   logic [skcc_pkg::ROW_AW-1:0]         req_idx;

   // stage 1: item waiting for store data
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s1_op_ff;
   logic [skcc_pkg::ROW_W-1:0]          s1_row_ff;
   logic [1:0]                          s1_init_ff;
   logic signed [skcc_pkg::VALUE_W-1:0] s1_value_ff;
   logic signed [skcc_pkg::VALUE_W-1:0] s1_key_ff;
   skcc_pkg::skcc_flags_type            s1_flags_ff;
   logic                                s1_first_ff;
   logic                                fwd_hit_ff, fwd_hit_in;
   logic [1:0]                          fwd_val_ff;

   // output word
   logic                                out_valid_ff, out_valid_in;
   logic [skcc_pkg::ROW_W-1:0]          out_row_ff;
   logic [1:0]                          out_result_ff;
   logic [skcc_pkg::TIE_W-1:0]          tie_ff;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !busy && (!s1_valid_ff || advance);
   assign accept    = req.valid && req.ready;

   // row index taken modulo ROWS (power of two)
   assign req_idx = req.row[skcc_pkg::ROW_AW-1:0];
   assign s1_idx  = s1_row_ff[skcc_pkg::ROW_AW-1:0];

   skcc_row_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_data),
      .wr      (wr),
      .busy    (busy)
   );

   skcc_cmp u_cmp (
      .value     (s1_value_ff),
      .key_value (s1_key_ff),
      .flags     (s1_flags_ff),
      .fresh     (fresh)
   );

   // read at the same edge as the previous word's write sees stale data
   assign old = fwd_hit_ff ? fwd_val_ff : rd_data;

   always_comb begin
      tie_in   = tie_ff;
      cnt_base = s1_first_ff ? '0 : tie_ff;
      if (s1_op_ff == skcc_pkg::OP_LOAD) begin
         r = skcc_pkg::init_code(s1_init_ff);
      end else begin
         r = (old == skcc_pkg::RES_TIED) ? fresh : old;
         tie_in = cnt_base;
         if (r == skcc_pkg::RES_TIED && cnt_base != skcc_pkg::TIE_MAX) begin
            tie_in = cnt_base + 1'b1;
         end
      end
   end

   always_comb begin
      wr.en   = advance;
      wr.addr = s1_idx;
      wr.data = r;
   end

   assign fwd_hit_in  = advance && (req_idx == s1_idx);
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_comb begin
      flags.descending    = req.descending;
      flags.null_sign_neg = req.null_sign_neg;
      flags.value_null    = req.value_null;
      flags.key_null      = req.key_null;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tie_ff       <= '0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            tie_ff <= tie_in;
         end
         if (accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req.op;
         s1_row_ff   <= req.row;
         s1_init_ff  <= req.init_result;
         s1_value_ff <= req.value;
         s1_key_ff   <= req.key_value;
         s1_flags_ff <= flags;
         s1_first_ff <= req.first_of_column;
         fwd_val_ff  <= r;
      end
      if (advance) begin
         out_row_ff    <= s1_row_ff;
         out_result_ff <= r;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.out_row    = out_row_ff;
   assign rsp.result     = out_result_ff;
   assign rsp.tied_count = tie_ff;

endmodule
